[rtl/light_morse_decoder_macros.svh]
// Assertion macros shared by the light Morse decoder RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef LIGHT_MORSE_DECODER_MACROS_SVH
`define LIGHT_MORSE_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LMD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("light_morse_decoder: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LMD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("light_morse_decoder: next-cycle check failed");

`endif

[rtl/lmd_pkg.sv]
// Types, constants and the letter table of the light Morse decoder.
// No dependencies; used by lmd_step and light_morse_decoder.
`timescale 1ns / 1ps

package lmd_pkg;

    localparam int ELEMENTS_PER_CODE = 4;
    localparam int SLOT_BITS         = $clog2(ELEMENTS_PER_CODE);
    localparam int CODE_BITS         = 2 * ELEMENTS_PER_CODE;
    localparam int DELTA_BITS        = 10;
    localparam int DARK_RUN_BITS     = 8;
    localparam int BRIGHT_RUN_BITS   = 4;
    localparam int KIND_BITS         = 2;
    localparam int LETTER_BITS       = 7;

    localparam logic [DELTA_BITS-1:0]      DELTA_RESET    = 10'd50;
    localparam logic [DARK_RUN_BITS-1:0]   DARK_RUN_MAX   = 8'd255;
    localparam logic [BRIGHT_RUN_BITS-1:0] BRIGHT_RUN_MAX = 4'd15;
    localparam logic [DARK_RUN_BITS-1:0]   DASH_MIN_RUN   = 8'd3;
    localparam logic [BRIGHT_RUN_BITS-1:0] LETTER_GAP     = 4'd3;
    localparam logic [BRIGHT_RUN_BITS-1:0] SPACE_RUN      = 4'd7;

    localparam logic [1:0] ELEMENT_DOT  = 2'b01;
    localparam logic [1:0] ELEMENT_DASH = 2'b11;

    localparam logic [KIND_BITS-1:0] KIND_LETTER = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_SPACE  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_END    = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_RUN
    } phase_t;

    typedef struct packed {
        phase_t                     phase;
        logic [DARK_RUN_BITS-1:0]   dark_run;
        logic [BRIGHT_RUN_BITS-1:0] bright_run;
        logic [CODE_BITS-1:0]       code_bits;
        logic [SLOT_BITS-1:0]       element_slot;
    } run_state_t;

    localparam run_state_t RUN_STATE_RESET = '{
        phase:        PH_IDLE,
        dark_run:     '0,
        bright_run:   '0,
        code_bits:    '0,
        element_slot: '0
    };

    typedef struct packed {
        logic                   valid;
        logic [KIND_BITS-1:0]   kind;
        logic [LETTER_BITS-1:0] letter;
    } symbol_t;

    // First element sits in bits 7:6; unused slots are 00.
    function automatic logic [LETTER_BITS-1:0] lookup_letter(input logic [CODE_BITS-1:0] code);
        logic [LETTER_BITS-1:0] ascii;
        case (code)
            8'h70:   ascii = 7'h41; // A
            8'hD5:   ascii = 7'h42; // B
            8'hDD:   ascii = 7'h43; // C
            8'hD4:   ascii = 7'h44; // D
            8'h40:   ascii = 7'h45; // E
            8'h5D:   ascii = 7'h46; // F
            8'hF4:   ascii = 7'h47; // G
            8'h55:   ascii = 7'h48; // H
            8'h50:   ascii = 7'h49; // I
            8'h7F:   ascii = 7'h4A; // J
            8'hDC:   ascii = 7'h4B; // K
            8'h75:   ascii = 7'h4C; // L
            8'hF0:   ascii = 7'h4D; // M
            8'hD0:   ascii = 7'h4E; // N
            8'hFC:   ascii = 7'h4F; // O
            8'h7D:   ascii = 7'h50; // P
            8'hF7:   ascii = 7'h51; // Q
            8'h74:   ascii = 7'h52; // R
            8'h54:   ascii = 7'h53; // S
            8'hC0:   ascii = 7'h54; // T
            8'h5C:   ascii = 7'h55; // U
            8'h57:   ascii = 7'h56; // V
            8'h7C:   ascii = 7'h57; // W
            8'hD7:   ascii = 7'h58; // X
            8'hDF:   ascii = 7'h59; // Y
            8'hF5:   ascii = 7'h5A; // Z
            default: ascii = '0;
        endcase
        return ascii;
    endfunction

endpackage

[rtl/lmd_if.sv]
// Valid/ready channel interfaces of the light Morse decoder.
// Depends on lmd_pkg for field widths.
`timescale 1ns / 1ps

interface lmd_sample_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] light_sample;
    logic                   abort;

    modport source (output valid, output light_sample, output abort, input ready);
    modport sink   (input valid, input light_sample, input abort, output ready);
endinterface

interface lmd_symbol_if;
    logic                           valid;
    logic                           ready;
    logic [lmd_pkg::KIND_BITS-1:0]   symbol_kind;
    logic [lmd_pkg::LETTER_BITS-1:0] letter;

    modport source (output valid, output symbol_kind, output letter, input ready);
    modport sink   (input valid, input symbol_kind, input letter, output ready);
endinterface

[rtl/lmd_step.sv]
// Next-state and symbol logic for one light sample of the Morse decoder.
// Depends on lmd_pkg; purely combinational, registered by the top level.
`timescale 1ns / 1ps

module lmd_step #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic [SAMPLE_BITS-1:0]         light_sample,
    input  logic                           abort,
    input  logic [SAMPLE_BITS-1:0]         baseline,
    input  logic [lmd_pkg::DELTA_BITS-1:0] dark_delta,
    input  lmd_pkg::run_state_t            state,
    output logic [SAMPLE_BITS-1:0]         baseline_next,
    output lmd_pkg::run_state_t            state_next,
    output lmd_pkg::symbol_t               symbol
);

    localparam int CMP_BITS =
        ((SAMPLE_BITS > lmd_pkg::DELTA_BITS) ? SAMPLE_BITS : lmd_pkg::DELTA_BITS) + 1;

    logic [CMP_BITS-1:0]                     sample_plus_delta;
    logic                                    dark;
    logic [lmd_pkg::DARK_RUN_BITS-1:0]       dark_run;
    logic [lmd_pkg::BRIGHT_RUN_BITS-1:0]     bright_run;
    logic [1:0]                              element;
    logic [lmd_pkg::CODE_BITS-1:0]           element_placed;

    // sample < baseline - delta, rearranged so that no negative value arises.
    assign sample_plus_delta = CMP_BITS'(light_sample) + CMP_BITS'(dark_delta);
    assign dark              = sample_plus_delta < CMP_BITS'(baseline);

    always_comb
    begin
        baseline_next  = baseline;
        state_next     = state;
        symbol         = '0;
        dark_run       = state.dark_run;
        bright_run     = state.bright_run;
        element        = (state.dark_run < lmd_pkg::DASH_MIN_RUN) ?
                         lmd_pkg::ELEMENT_DOT : lmd_pkg::ELEMENT_DASH;
        element_placed = '0;

        if (abort)
        begin
            state_next = lmd_pkg::RUN_STATE_RESET;
        end
        else
        begin
            case (state.phase)
                lmd_pkg::PH_IDLE:
                begin
                    baseline_next    = light_sample;
                    state_next.phase = lmd_pkg::PH_WAIT;
                end
                lmd_pkg::PH_WAIT:
                begin
                    if (dark)
                    begin
                        state_next          = lmd_pkg::RUN_STATE_RESET;
                        state_next.phase    = lmd_pkg::PH_RUN;
                        state_next.dark_run = lmd_pkg::DARK_RUN_BITS'(1);
                    end
                end
                lmd_pkg::PH_RUN:
                begin
                    if (dark)
                    begin
                        if (dark_run != lmd_pkg::DARK_RUN_MAX)
                        begin
                            dark_run = dark_run + lmd_pkg::DARK_RUN_BITS'(1);
                        end
                        bright_run = '0;
                    end
                    else if (bright_run != lmd_pkg::BRIGHT_RUN_MAX)
                    begin
                        bright_run = bright_run + lmd_pkg::BRIGHT_RUN_BITS'(1);
                    end
                    state_next.dark_run   = dark_run;
                    state_next.bright_run = bright_run;

                    if (bright_run != '0 && dark_run != '0)
                    begin
                        // A bright sample closes a dark run: pack one element.
                        element_placed = {element, {(lmd_pkg::CODE_BITS-2){1'b0}}}
                                         >> {state.element_slot, 1'b0};
                        state_next.code_bits    = state.code_bits | element_placed;
                        state_next.element_slot = state.element_slot
                                                  + lmd_pkg::SLOT_BITS'(1);
                        state_next.dark_run     = '0;
                    end
                    else if (bright_run >= lmd_pkg::LETTER_GAP && state.code_bits != '0)
                    begin
                        symbol.valid            = 1'b1;
                        symbol.kind             = lmd_pkg::KIND_LETTER;
                        symbol.letter           = lmd_pkg::lookup_letter(state.code_bits);
                        state_next.code_bits    = '0;
                        state_next.element_slot = '0;
                    end
                    else if (bright_run == lmd_pkg::SPACE_RUN)
                    begin
                        symbol.valid = 1'b1;
                        symbol.kind  = lmd_pkg::KIND_SPACE;
                    end
                    else if (bright_run > lmd_pkg::SPACE_RUN)
                    begin
                        symbol.valid = 1'b1;
                        symbol.kind  = lmd_pkg::KIND_END;
                        state_next   = lmd_pkg::RUN_STATE_RESET;
                    end
                end
                default:
                begin
                    state_next = lmd_pkg::RUN_STATE_RESET;
                end
            endcase
        end
    end

endmodule

[rtl/light_morse_decoder.sv]
// Light-sensor Morse receiver: takes one sample per transaction, emits letters,
// word spaces and end of message. One sample is accepted in every clock cycle;
// its symbol, if any, appears on the symbol channel in the next cycle from a
// single result register, and sampling stalls only while that register holds a
// symbol that the sink has not taken. The per-sample work is one compare, two
// saturating counters and a letter lookup on the 8-bit code between registers.
// Depends on lmd_pkg, lmd_if, lmd_step and light_morse_decoder_macros.svh.
`timescale 1ns / 1ps

`include "light_morse_decoder_macros.svh"

module light_morse_decoder #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lmd_pkg::DELTA_BITS-1:0] cfg_wdata,
    lmd_sample_if.sink                     samples,
    lmd_symbol_if.source                   symbols
);

    logic [lmd_pkg::DELTA_BITS-1:0]  dark_delta_reg;
    logic [SAMPLE_BITS-1:0]          baseline_reg;
    logic [SAMPLE_BITS-1:0]          baseline_next;
    lmd_pkg::run_state_t             state_reg;
    lmd_pkg::run_state_t             state_next;
    lmd_pkg::symbol_t                symbol;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [lmd_pkg::KIND_BITS-1:0]   out_kind_reg;
    logic [lmd_pkg::LETTER_BITS-1:0] out_letter_reg;
    logic                            accept;

    lmd_step #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .light_sample  (samples.light_sample),
        .abort         (samples.abort),
        .baseline      (baseline_reg),
        .dark_delta    (dark_delta_reg),
        .state         (state_reg),
        .baseline_next (baseline_next),
        .state_next    (state_next),
        .symbol        (symbol)
    );

    // The result register frees up in the same cycle that the sink takes it.
    assign samples.ready = !out_valid_reg || symbols.ready;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = symbol.valid;
        end
        else if (symbols.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_delta_reg <= lmd_pkg::DELTA_RESET;
            baseline_reg   <= '0;
            state_reg      <= lmd_pkg::RUN_STATE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dark_delta_reg <= cfg_wdata;
            end
            if (accept)
            begin
                baseline_reg <= baseline_next;
                state_reg    <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && symbol.valid)
        begin
            out_kind_reg   <= symbol.kind;
            out_letter_reg <= symbol.letter;
        end
    end

    assign symbols.valid       = out_valid_reg;
    assign symbols.symbol_kind = out_kind_reg;
    assign symbols.letter      = out_letter_reg;

    `LMD_ASSERT_IMP(a_no_accept_when_blocked, symbols.valid && !symbols.ready, !samples.ready)
    `LMD_ASSERT_IMP(a_run_counters_clear_outside_run, state_reg.phase != lmd_pkg::PH_RUN,
        {state_reg.dark_run, state_reg.bright_run, state_reg.code_bits,
         state_reg.element_slot} == '0)
    `LMD_ASSERT_IMP(a_bright_run_below_end, 1'b1, state_reg.bright_run <= lmd_pkg::SPACE_RUN)
    `LMD_ASSERT_NXT(a_end_returns_idle, accept && symbol.valid && symbol.kind == lmd_pkg::KIND_END,
        state_reg.phase == lmd_pkg::PH_IDLE && symbols.valid)
    `LMD_ASSERT_IMP(a_letter_only_for_letters,
        symbols.valid && symbols.symbol_kind != lmd_pkg::KIND_LETTER, symbols.letter == '0)

endmodule

[bench/tb_light_morse_decoder.sv]
// Self-checking testbench for light_morse_decoder: random and directed light samples,
// an in-bench decoder that predicts every symbol, and a checker on the symbol channel.
// Depends on lmd_pkg, lmd_if and the light_morse_decoder RTL.
`timescale 1ns / 1ps

module tb_light_morse_decoder;

    localparam int SAMPLE_W = 10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic                abort;
    } sample_txn_t;

    typedef struct packed {
        logic [lmd_pkg::KIND_BITS-1:0]   kind;
        logic [lmd_pkg::LETTER_BITS-1:0] letter;
    } symbol_exp_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [lmd_pkg::DELTA_BITS-1:0] cfg_wdata;

    lmd_sample_if #(.SAMPLE_BITS(SAMPLE_W)) sample_ch ();
    lmd_symbol_if symbol_ch ();

    light_morse_decoder #(.SAMPLE_BITS(SAMPLE_W)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (sample_ch),
        .symbols   (symbol_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stimulus and expectation stores.
    sample_txn_t pending_samples[$];
    symbol_exp_t expected_symbols[$];
    logic        gaps_on;
    int unsigned gen_delta;
    int unsigned queued_in_phase;

    // Decoder state mirrored by the bench.
    logic [lmd_pkg::LETTER_BITS-1:0] letter_of_code [0:255];
    lmd_pkg::phase_t                 run_phase;
    logic [lmd_pkg::DELTA_BITS-1:0]  delta_copy;
    logic [SAMPLE_W-1:0]             base_level;
    logic [7:0]                      dark_len;
    logic [3:0]                      bright_len;
    logic [7:0]                      code_reg;
    logic [1:0]                      slot;

    int unsigned samples_sent;
    int unsigned letters_seen;
    int unsigned unknown_seen;
    int unsigned spaces_seen;
    int unsigned ends_seen;
    int unsigned mismatch_count;

    sample_txn_t next_txn;
    symbol_exp_t predicted;
    symbol_exp_t want;

    string morse_pattern [0:25] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
    };

    function automatic void clear_decode();
        run_phase  = lmd_pkg::PH_IDLE;
        dark_len   = '0;
        bright_len = '0;
        code_reg   = '0;
        slot       = '0;
    endfunction

    // Advances the mirrored decoder by one accepted sample; returns 1 when a symbol is due.
    function automatic bit decode_sample(input logic [SAMPLE_W-1:0] level, input logic abrt,
                                         output symbol_exp_t sym);
        int          thresh;
        bit          is_dark;
        logic [1:0]  elem;
        int          shift;
        thresh  = int'(base_level) - int'(delta_copy);
        is_dark = int'(level) < thresh;
        sym     = '0;
        if (abrt)
        begin
            clear_decode();
            return 0;
        end
        if (run_phase == lmd_pkg::PH_IDLE)
        begin
            base_level = level;
            run_phase  = lmd_pkg::PH_WAIT;
            return 0;
        end
        if (run_phase == lmd_pkg::PH_WAIT)
        begin
            if (is_dark)
            begin
                run_phase  = lmd_pkg::PH_RUN;
                dark_len   = 8'd1;
                bright_len = '0;
                code_reg   = '0;
                slot       = '0;
            end
            return 0;
        end
        if (is_dark)
        begin
            if (dark_len != 8'd255)
                dark_len = dark_len + 8'd1;
            bright_len = '0;
        end
        else if (bright_len != 4'd15)
        begin
            bright_len = bright_len + 4'd1;
        end
        if (bright_len != 0 && dark_len != 0)
        begin
            elem     = (dark_len < lmd_pkg::DASH_MIN_RUN) ?
                       lmd_pkg::ELEMENT_DOT : lmd_pkg::ELEMENT_DASH;
            shift    = 6 - 2 * int'(slot);
            code_reg = code_reg | ({6'd0, elem} << shift);
            slot     = slot + 2'd1;
            dark_len = '0;
            return 0;
        end
        if (bright_len >= lmd_pkg::LETTER_GAP && code_reg != 0)
        begin
            sym.kind   = lmd_pkg::KIND_LETTER;
            sym.letter = letter_of_code[code_reg];
            code_reg   = '0;
            slot       = '0;
            return 1;
        end
        if (bright_len == lmd_pkg::SPACE_RUN)
        begin
            sym.kind = lmd_pkg::KIND_SPACE;
            return 1;
        end
        if (bright_len > lmd_pkg::SPACE_RUN)
        begin
            sym.kind = lmd_pkg::KIND_END;
            clear_decode();
            return 1;
        end
        return 0;
    endfunction

    // Sample driver; the decoder mirror advances on every accepted transaction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid        <= 1'b0;
            sample_ch.light_sample <= '0;
            sample_ch.abort        <= 1'b0;
            delta_copy   = lmd_pkg::DELTA_RESET;
            base_level   = '0;
            clear_decode();
            samples_sent = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                samples_sent++;
                if (decode_sample(sample_ch.light_sample, sample_ch.abort, predicted))
                    expected_symbols.push_back(predicted);
            end
            // The new threshold applies from the next transaction on.
            if (cfg_we)
                delta_copy = cfg_wdata;
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (pending_samples.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 17))
                begin
                    next_txn = pending_samples.pop_front();
                    sample_ch.valid        <= 1'b1;
                    sample_ch.light_sample <= next_txn.level;
                    sample_ch.abort        <= next_txn.abort;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Symbol monitor and checker.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            symbol_ch.ready <= 1'b0;
            letters_seen   = 0;
            unknown_seen   = 0;
            spaces_seen    = 0;
            ends_seen      = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (symbol_ch.valid && symbol_ch.ready)
            begin
                if (expected_symbols.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected symbol kind %0d letter %0d", $time,
                                 symbol_ch.symbol_kind, symbol_ch.letter);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_symbols.pop_front();
                    if (symbol_ch.symbol_kind !== want.kind || symbol_ch.letter !== want.letter)
                    begin
                        if (mismatch_count < 10)
                            $display({"%0t: symbol mismatch: expected kind %0d letter %0d,",
                                      " got kind %0d letter %0d"},
                                     $time, want.kind, want.letter,
                                     symbol_ch.symbol_kind, symbol_ch.letter);
                        mismatch_count++;
                    end
                    if (want.kind == lmd_pkg::KIND_SPACE)
                        spaces_seen++;
                    else if (want.kind == lmd_pkg::KIND_END)
                        ends_seen++;
                    else if (want.letter == 0)
                        unknown_seen++;
                    else
                        letters_seen++;
                end
            end
            symbol_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 17);
        end
    end

    task automatic queue_sample(input int unsigned level, input logic abrt);
        sample_txn_t txn;
        txn.level = level[SAMPLE_W-1:0];
        txn.abort = abrt;
        pending_samples.push_back(txn);
        queued_in_phase++;
    endtask

    // One keyed message: baseline, letters of random dots and dashes, gaps, end of message.
    // A broken message is cut short by an abort part way through.
    task automatic queue_message(input bit broken);
        int unsigned base;
        int unsigned lo_bright;
        int unsigned start;
        int unsigned cut;
        int unsigned n_letters;
        int unsigned n_elems;
        int unsigned run_len;
        int unsigned gap;
        start = queued_in_phase;
        cut   = $urandom_range(3, 25);
        queue_sample($urandom_range(0, 1023), 1'b1);
        base      = $urandom_range(gen_delta + 1, 1023);
        lo_bright = base - gen_delta;
        queue_sample(base, 1'b0);
        repeat ($urandom_range(0, 3)) queue_sample($urandom_range(lo_bright, 1023), 1'b0);
        n_letters = $urandom_range(1, 5);
        for (int l = 0; l < n_letters; l++)
        begin
            n_elems = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            for (int e = 0; e < n_elems; e++)
            begin
                if (broken && queued_in_phase - start >= cut)
                begin
                    queue_sample($urandom_range(0, 1023), 1'b1);
                    return;
                end
                if ($urandom_range(0, 39) == 0)
                    run_len = $urandom_range(250, 270);
                else if ($urandom_range(0, 1) == 0)
                    run_len = $urandom_range(1, 2);
                else
                    run_len = $urandom_range(3, 6);
                repeat (run_len) queue_sample($urandom_range(0, lo_bright - 1), 1'b0);
                if (e + 1 < n_elems)
                    repeat ($urandom_range(1, 2))
                        queue_sample($urandom_range(lo_bright, 1023), 1'b0);
            end
            if (l + 1 < n_letters)
                gap = ($urandom_range(0, 3) == 0) ? lmd_pkg::SPACE_RUN : $urandom_range(3, 6);
            else
                gap = $urandom_range(8, 10);
            repeat (gap) queue_sample($urandom_range(lo_bright, 1023), 1'b0);
        end
    endtask

    task automatic queue_random_phase(input int unsigned target);
        int unsigned pick;
        queued_in_phase = 0;
        while (queued_in_phase < target)
        begin
            pick = $urandom_range(0, 9);
            if (gen_delta < 1023 && pick < 7)
                queue_message(1'b0);
            else if (gen_delta < 1023 && pick == 7)
                queue_message(1'b1);
            else
                repeat ($urandom_range(1, 8))
                    queue_sample($urandom_range(0, 1023), $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || sample_ch.valid || expected_symbols.size() != 0)
            @(posedge clk);
        // Samples that cause no symbol may still be in flight.
        repeat (4) @(posedge clk);
    endtask

    task automatic write_delta(input int unsigned value, input logic with_gaps);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[lmd_pkg::DELTA_BITS-1:0];
        gaps_on   <= with_gaps;
        gen_delta = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned code;
        int unsigned shift;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        gaps_on   = 1'b1;
        gen_delta = lmd_pkg::DELTA_RESET;

        for (int c = 0; c < 256; c++)
            letter_of_code[c] = '0;
        for (int k = 0; k < 26; k++)
        begin
            code  = 0;
            shift = 6;
            for (int i = 0; i < morse_pattern[k].len(); i++)
            begin
                code  = code | (((morse_pattern[k][i] == "-") ? 3 : 1) << shift);
                shift = shift - 2;
            end
            letter_of_code[code] = 7'(65 + k);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset threshold of 50: abort while idle, full-scale
        // baseline, a dot read as E followed by word space and end of message.
        queue_sample(1023, 1'b1);
        queue_sample(1023, 1'b0);
        queue_sample(0, 1'b0);
        repeat (8) queue_sample(1000, 1'b0);
        // A baseline below the threshold: nothing counts as dark until an abort.
        queue_sample(10, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(0, 1'b1);
        // Dash then four dots: the fifth element wraps onto the first slot.
        queue_sample(1023, 1'b0);
        repeat (3) queue_sample(0, 1'b0);
        queue_sample(1000, 1'b0);
        repeat (4)
        begin
            queue_sample(0, 1'b0);
            queue_sample(1000, 1'b0);
        end
        // Abort in the middle of a letter.
        queue_sample(512, 1'b1);

        write_delta(0, 1'b1);
        queue_random_phase(110);
        write_delta(1023, 1'b1);
        queue_random_phase(40);
        // Long stretch without any idling on either side.
        write_delta($urandom_range(1, 300), 1'b0);
        queue_random_phase(240);
        write_delta($urandom_range(1, 600), 1'b1);
        queue_random_phase(330);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d samples over five threshold settings, including 0 and 1023.",
                 samples_sent);
        $display("Received %0d letters, %0d unknown codes, %0d word spaces, %0d message ends.",
                 letters_seen, unknown_seen, spaces_seen, ends_seen);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d symbols outstanding.", expected_symbols.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
